// ===== sv/rsi_pkg.sv =====
`default_nettype none
package rsi_pkg;

	// pair type: first primitive, then second
	typedef enum logic [1:0] {
		CMD_RAY_RAY = 2'd0,
		CMD_RAY_SEG = 2'd1,
		CMD_SEG_SEG = 2'd2,
		CMD_SEG_RAY = 2'd3
	} cmd_t;

	// per-item status carried alongside the divider row
	typedef struct packed {
		logic hit;
		logic parallel;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
	} flags_t;

	localparam int FlagsWidth = $bits(flags_t);

endpackage
`default_nettype wire

// ===== sv/rsi_item_if.sv =====
`default_nettype none
interface rsi_item_if #(
	parameter int W = 32
);
	logic             valid;
	logic             ready;
	rsi_pkg::cmd_t    cmd;
	logic signed [W-1:0] first_origin_x;
	logic signed [W-1:0] first_origin_y;
	logic signed [W-1:0] first_dir_x;
	logic signed [W-1:0] first_dir_y;
	logic signed [W-1:0] second_origin_x;
	logic signed [W-1:0] second_origin_y;
	logic signed [W-1:0] second_dir_x;
	logic signed [W-1:0] second_dir_y;

	modport source (
		output valid, cmd, first_origin_x, first_origin_y, first_dir_x, first_dir_y,
			second_origin_x, second_origin_y, second_dir_x, second_dir_y,
		input ready
	);
	modport sink (
		input valid, cmd, first_origin_x, first_origin_y, first_dir_x, first_dir_y,
			second_origin_x, second_origin_y, second_dir_x, second_dir_y,
		output ready
	);
endinterface
`default_nettype wire

// ===== sv/rsi_result_if.sv =====
`default_nettype none
interface rsi_result_if #(
	parameter int W = 32
);
	logic             valid;
	logic             ready;
	logic             hit;
	logic             parallel;
	logic signed [W-1:0] point_x;
	logic signed [W-1:0] point_y;
	logic             clipped;

	modport source (
		output valid, hit, parallel, point_x, point_y, clipped,
		input ready
	);
	modport sink (
		input valid, hit, parallel, point_x, point_y, clipped,
		output ready
	);
endinterface
`default_nettype wire

// ===== sv/ray_segment_intersect_2d.sv =====
`default_nettype none
// Between item transfer and result: 8 front stages, COORD_WIDTH + 1 divider cells,
//   1 output register.
// Throughput: one item per cycle while results are taken. Every stage is elastic:
//   bubbles close up, and input transfers continue while a result waits at output.
// Reset: arst_n clears only the stage valid flags; datapath is not reset.
module ray_segment_intersect_2d #(
	parameter int COORD_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	rsi_item_if.sink     item,
	rsi_result_if.source result
);
	import rsi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = 2 * W + 1;   // positive determinant
	localparam int Q  = W + 1;       // quotient bits kept; above that saturates anyway
	localparam int SW = 2 * W + FlagsWidth;

	// Front end: origin offset, cross products (Cramer's rule), sign
	// normalisation, exact range tests and |dir| * |N1| as partial products.
	logic          f_valid, f_ready;
	logic [DW-1:0] f_den, f_rem_x, f_rem_y;
	logic [Q-1:0]  f_nq_x, f_nq_y;
	logic signed [W-1:0] f_ox, f_oy;
	flags_t        f_flags;

	rsi_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.div_valid (f_valid),
		.div_ready (f_ready),
		.den       (f_den),
		.rem_x     (f_rem_x),
		.rem_y     (f_rem_y),
		.nq_x      (f_nq_x),
		.nq_y      (f_nq_y),
		.orig_x    (f_ox),
		.orig_y    (f_oy),
		.flags     (f_flags)
	);

	// Divider row: one cell per quotient bit, x and y lanes side by side,
	// sharing the determinant. Origins and flags ride along.
	logic          c_valid [0:Q];
	logic          c_ready [0:Q];
	logic [DW-1:0] c_den   [0:Q];
	logic [DW-1:0] c_rem_x [0:Q];
	logic [DW-1:0] c_rem_y [0:Q];
	logic [Q-1:0]  c_nq_x  [0:Q];
	logic [Q-1:0]  c_nq_y  [0:Q];
	logic [SW-1:0] c_side  [0:Q];

	assign c_valid[0] = f_valid;
	assign f_ready    = c_ready[0];
	assign c_den[0]   = f_den;
	assign c_rem_x[0] = f_rem_x;
	assign c_rem_y[0] = f_rem_y;
	assign c_nq_x[0]  = f_nq_x;
	assign c_nq_y[0]  = f_nq_y;
	assign c_side[0]  = {f_ox, f_oy, f_flags};

	for (genvar i = 0; i < Q; i++) begin : g_cell
		rsi_div_cell #(.DW(DW), .Q(Q), .SW(SW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_valid (c_valid[i]),
			.prev_ready (c_ready[i]),
			.prev_den   (c_den[i]),
			.prev_rem_x (c_rem_x[i]),
			.prev_rem_y (c_rem_y[i]),
			.prev_nq_x  (c_nq_x[i]),
			.prev_nq_y  (c_nq_y[i]),
			.prev_side  (c_side[i]),
			.next_valid (c_valid[i+1]),
			.next_ready (c_ready[i+1]),
			.next_den   (c_den[i+1]),
			.next_rem_x (c_rem_x[i+1]),
			.next_rem_y (c_rem_y[i+1]),
			.next_nq_x  (c_nq_x[i+1]),
			.next_nq_y  (c_nq_y[i+1]),
			.next_side  (c_side[i+1])
		);
	end

	// Output stage: apply sign of the offset, add origin, saturate.
	// Quotient reaches 2^(W+1) - 1, so the sum needs three guard bits.
	logic signed [W-1:0] ox, oy;
	flags_t fl;
	assign {ox, oy, fl} = c_side[Q];

	logic [W+2:0] qx_ext, qy_ext, rx, ry;
	assign qx_ext = {2'b00, c_nq_x[Q]};
	assign qy_ext = {2'b00, c_nq_y[Q]};
	assign rx = {{3{ox[W-1]}}, ox} + (fl.neg_x ? -qx_ext : qx_ext);
	assign ry = {{3{oy[W-1]}}, oy} + (fl.neg_y ? -qy_ext : qy_ext);

	localparam logic [W-1:0] MaxC = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MinC = {1'b1, {(W-1){1'b0}}};

	logic xr_out, yr_out;  // sum left the coordinate range
	assign xr_out = ~((rx[W+2:W-1] == '0) || (rx[W+2:W-1] == '1));
	assign yr_out = ~((ry[W+2:W-1] == '0) || (ry[W+2:W-1] == '1));

	logic [W-1:0] px, py;
	logic clx, cly;
	always_comb begin
		if (fl.ovf_x) begin
			px = fl.neg_x ? MinC : MaxC;
			clx = 1'b1;
		end else if (xr_out) begin
			px = rx[W+2] ? MinC : MaxC;
			clx = 1'b1;
		end else begin
			px = rx[W-1:0];
			clx = 1'b0;
		end
		if (fl.ovf_y) begin
			py = fl.neg_y ? MinC : MaxC;
			cly = 1'b1;
		end else if (yr_out) begin
			py = ry[W+2] ? MinC : MaxC;
			cly = 1'b1;
		end else begin
			py = ry[W-1:0];
			cly = 1'b0;
		end
	end

	logic out_v_q;
	assign c_ready[Q] = ~out_v_q | result.ready;
	assign result.valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (c_ready[Q]) begin
			out_v_q <= c_valid[Q];
		end
	end

	// parallel (zero determinant) forces a zero point and no clip
	always_ff @(posedge clk) begin
		if (c_ready[Q]) begin
			result.hit      <= fl.hit;
			result.parallel <= fl.parallel;
			result.point_x  <= fl.parallel ? '0 : px;
			result.point_y  <= fl.parallel ? '0 : py;
			result.clipped  <= ~fl.parallel & (clx | cly);
		end
	end

endmodule
`default_nettype wire

// ===== sv/rsi_front.sv =====
`default_nettype none
module rsi_front #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rsi_item_if.sink              item,
	output logic                  div_valid,
	input  logic                  div_ready,
	output logic [2*W:0]          den,
	output logic [2*W:0]          rem_x,
	output logic [2*W:0]          rem_y,
	output logic [W:0]            nq_x,
	output logic [W:0]            nq_y,
	output logic signed [W-1:0]   orig_x,
	output logic signed [W-1:0]   orig_y,
	output rsi_pkg::flags_t       flags
);
	import rsi_pkg::*;

	localparam int PW  = 2 * W;
	localparam int DW  = 2 * W + 1;
	localparam int NW  = 2 * W + 2;
	localparam int MW  = 2 * W + 1;
	localparam int Q   = W + 1;
	localparam int PRW = 3 * W + 1;
	localparam int NS  = 8;

	logic [NS:1]   v_q;
	logic [NS+1:1] adv;
	logic [NS:1]   vin;

	always_comb begin
		adv[NS+1] = div_ready;
		for (int k = NS; k >= 1; k--) adv[k] = ~v_q[k] | adv[k+1];
	end
	assign vin = {v_q[NS-1:1], item.valid};
	assign item.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) if (adv[k]) v_q[k] <= vin[k];
		end
	end

	// s1: offset between origins
	logic seg1_s1, seg2_s1;
	logic signed [W-1:0] p1x_s1, p1y_s1, d1x_s1, d1y_s1, d2x_s1, d2y_s1;
	logic signed [W:0] vx_s1, vy_s1;
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			seg1_s1 <= (item.cmd == CMD_SEG_SEG) || (item.cmd == CMD_SEG_RAY);
			seg2_s1 <= (item.cmd == CMD_RAY_SEG) || (item.cmd == CMD_SEG_SEG);
			p1x_s1 <= item.first_origin_x;
			p1y_s1 <= item.first_origin_y;
			d1x_s1 <= item.first_dir_x;
			d1y_s1 <= item.first_dir_y;
			d2x_s1 <= item.second_dir_x;
			d2y_s1 <= item.second_dir_y;
			vx_s1 <= $signed({item.second_origin_x[W-1], item.second_origin_x})
				- $signed({item.first_origin_x[W-1], item.first_origin_x});
			vy_s1 <= $signed({item.second_origin_y[W-1], item.second_origin_y})
				- $signed({item.first_origin_y[W-1], item.first_origin_y});
		end
	end

	// s2: six products of the cross terms
	logic seg1_s2, seg2_s2;
	logic signed [W-1:0] p1x_s2, p1y_s2, d1x_s2, d1y_s2;
	logic signed [PW-1:0] ma_s2, mb_s2;
	logic signed [PW:0] mc_s2, md_s2, me_s2, mf_s2;
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			seg1_s2 <= seg1_s1;
			seg2_s2 <= seg2_s1;
			p1x_s2 <= p1x_s1;
			p1y_s2 <= p1y_s1;
			d1x_s2 <= d1x_s1;
			d1y_s2 <= d1y_s1;
			ma_s2 <= d1x_s1 * d2y_s1;
			mb_s2 <= d1y_s1 * d2x_s1;
			mc_s2 <= vx_s1 * d2y_s1;
			md_s2 <= vy_s1 * d2x_s1;
			me_s2 <= vx_s1 * d1y_s1;
			mf_s2 <= vy_s1 * d1x_s1;
		end
	end

	// s3: determinant and numerators
	logic seg1_s3, seg2_s3;
	logic signed [W-1:0] p1x_s3, p1y_s3, d1x_s3, d1y_s3;
	logic signed [DW-1:0] den_s3;
	logic signed [NW-1:0] n1_s3, n2_s3;
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			seg1_s3 <= seg1_s2;
			seg2_s3 <= seg2_s2;
			p1x_s3 <= p1x_s2;
			p1y_s3 <= p1y_s2;
			d1x_s3 <= d1x_s2;
			d1y_s3 <= d1y_s2;
			den_s3 <= ma_s2 - mb_s2;
			n1_s3 <= mc_s2 - md_s2;
			n2_s3 <= me_s2 - mf_s2;
		end
	end

	// s4: make the determinant positive
	logic seg1_s4, seg2_s4, par_s4;
	logic signed [W-1:0] p1x_s4, p1y_s4, d1x_s4, d1y_s4;
	logic [DW-1:0] den_s4;
	logic signed [NW-1:0] n1_s4, n2_s4;
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			seg1_s4 <= seg1_s3;
			seg2_s4 <= seg2_s3;
			p1x_s4 <= p1x_s3;
			p1y_s4 <= p1y_s3;
			d1x_s4 <= d1x_s3;
			d1y_s4 <= d1y_s3;
			par_s4 <= (den_s3 == '0);
			den_s4 <= den_s3[DW-1] ? DW'(-den_s3) : DW'(den_s3);
			n1_s4 <= den_s3[DW-1] ? -n1_s3 : n1_s3;
			n2_s4 <= den_s3[DW-1] ? -n2_s3 : n2_s3;
		end
	end

	// s5: exact range tests, magnitudes
	logic ok1, ok2;
	logic [NW-1:0] n1_abs;
	assign ok1 = ~n1_s4[NW-1] & (~seg1_s4 | (NW'(n1_s4) <= {1'b0, den_s4}));
	assign ok2 = ~n2_s4[NW-1] & (~seg2_s4 | (NW'(n2_s4) <= {1'b0, den_s4}));
	assign n1_abs = n1_s4[NW-1] ? NW'(-n1_s4) : NW'(n1_s4);

	logic hit_s5, par_s5, sn1_s5, sdx_s5, sdy_s5;
	logic signed [W-1:0] p1x_s5, p1y_s5;
	logic [W-1:0] adx_s5, ady_s5;
	logic [MW-1:0] mag1_s5;
	logic [DW-1:0] den_s5;
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			hit_s5 <= ok1 & ok2 & ~par_s4;
			par_s5 <= par_s4;
			sn1_s5 <= n1_s4[NW-1];
			sdx_s5 <= d1x_s4[W-1];
			sdy_s5 <= d1y_s4[W-1];
			adx_s5 <= d1x_s4[W-1] ? W'(-d1x_s4) : W'(d1x_s4);
			ady_s5 <= d1y_s4[W-1] ? W'(-d1y_s4) : W'(d1y_s4);
			mag1_s5 <= n1_abs[MW-1:0];
			den_s5 <= den_s4;
			p1x_s5 <= p1x_s4;
			p1y_s5 <= p1y_s4;
		end
	end

	// s6: partial products of direction by numerator
	logic hit_s6, par_s6, negx_s6, negy_s6;
	logic signed [W-1:0] p1x_s6, p1y_s6;
	logic [DW-1:0] den_s6;
	logic [2*W:0] pxh_s6, pyh_s6;
	logic [2*W-1:0] pxl_s6, pyl_s6;
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			hit_s6 <= hit_s5;
			par_s6 <= par_s5;
			negx_s6 <= sdx_s5 ^ sn1_s5;
			negy_s6 <= sdy_s5 ^ sn1_s5;
			p1x_s6 <= p1x_s5;
			p1y_s6 <= p1y_s5;
			den_s6 <= den_s5;
			pxh_s6 <= adx_s5 * mag1_s5[MW-1:W];
			pxl_s6 <= adx_s5 * mag1_s5[W-1:0];
			pyh_s6 <= ady_s5 * mag1_s5[MW-1:W];
			pyl_s6 <= ady_s5 * mag1_s5[W-1:0];
		end
	end

	// s7: recombine
	logic hit_s7, par_s7, negx_s7, negy_s7;
	logic signed [W-1:0] p1x_s7, p1y_s7;
	logic [DW-1:0] den_s7;
	logic [PRW-1:0] prx_s7, pry_s7;
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			hit_s7 <= hit_s6;
			par_s7 <= par_s6;
			negx_s7 <= negx_s6;
			negy_s7 <= negy_s6;
			p1x_s7 <= p1x_s6;
			p1y_s7 <= p1y_s6;
			den_s7 <= den_s6;
			prx_s7 <= {pxh_s6, {W{1'b0}}} + PRW'(pxl_s6);
			pry_s7 <= {pyh_s6, {W{1'b0}}} + PRW'(pyl_s6);
		end
	end

	// s8: quotient overflow test, seed the divider row
	logic ovx, ovy;
	assign ovx = {1'b0, prx_s7[PRW-1:Q]} >= den_s7;
	assign ovy = {1'b0, pry_s7[PRW-1:Q]} >= den_s7;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			den <= den_s7;
			rem_x <= ovx ? '0 : {1'b0, prx_s7[PRW-1:Q]};
			rem_y <= ovy ? '0 : {1'b0, pry_s7[PRW-1:Q]};
			nq_x <= prx_s7[Q-1:0];
			nq_y <= pry_s7[Q-1:0];
			orig_x <= p1x_s7;
			orig_y <= p1y_s7;
			flags.hit <= hit_s7;
			flags.parallel <= par_s7;
			flags.neg_x <= negx_s7;
			flags.neg_y <= negy_s7;
			flags.ovf_x <= ovx;
			flags.ovf_y <= ovy;
		end
	end
	assign div_valid = v_q[NS];

endmodule
`default_nettype wire

// ===== sv/rsi_div_cell.sv =====
`default_nettype none
module rsi_div_cell #(
	parameter int DW = 65,
	parameter int Q  = 33,
	parameter int SW = 70
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          prev_valid,
	output logic          prev_ready,
	input  logic [DW-1:0] prev_den,
	input  logic [DW-1:0] prev_rem_x,
	input  logic [DW-1:0] prev_rem_y,
	input  logic [Q-1:0]  prev_nq_x,
	input  logic [Q-1:0]  prev_nq_y,
	input  logic [SW-1:0] prev_side,
	output logic          next_valid,
	input  logic          next_ready,
	output logic [DW-1:0] next_den,
	output logic [DW-1:0] next_rem_x,
	output logic [DW-1:0] next_rem_y,
	output logic [Q-1:0]  next_nq_x,
	output logic [Q-1:0]  next_nq_y,
	output logic [SW-1:0] next_side
);
	// one restoring step per lane: bring in the next numerator bit,
	// subtract when it fits, shift the quotient bit in at the bottom
	logic [DW:0] rx2, ry2, dext;
	logic gx, gy;
	logic [DW:0] rxn, ryn;

	assign dext = {1'b0, prev_den};
	assign rx2 = {prev_rem_x, prev_nq_x[Q-1]};
	assign ry2 = {prev_rem_y, prev_nq_y[Q-1]};
	assign gx = rx2 >= dext;
	assign gy = ry2 >= dext;
	assign rxn = gx ? rx2 - dext : rx2;
	assign ryn = gy ? ry2 - dext : ry2;

	logic v_q;
	assign prev_ready = ~v_q | next_ready;
	assign next_valid = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (prev_ready) begin
			v_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_ready) begin
			next_den <= prev_den;
			next_rem_x <= rxn[DW-1:0];
			next_rem_y <= ryn[DW-1:0];
			next_nq_x <= {prev_nq_x[Q-2:0], gx};
			next_nq_y <= {prev_nq_y[Q-2:0], gy};
			next_side <= prev_side;
		end
	end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import rsi_pkg::*;

	localparam int W = 32;
	localparam logic signed [W-1:0] ONE = 32'sh0001_0000;
	localparam logic signed [W-1:0] CMAX = 32'sh7fff_ffff;
	localparam logic signed [W-1:0] CMIN = 32'sh8000_0000;
	localparam int RANDOM_PAIRS = 400;
	localparam int DRAIN_CYCLES = 80;     // pipeline is 42 deep at 32 bits
	localparam int CYCLE_LIMIT = 200000;

	// exact intermediates: cross products are ~67 bits, offset products ~99 bits
	typedef logic signed [127:0] exact_t;

	typedef struct {
		cmd_t cmd;
		logic signed [W-1:0] fox, foy, fdx, fdy;
		logic signed [W-1:0] sox, soy, sdx, sdy;
	} pair_t;

	typedef struct {
		logic hit;
		logic parallel;
		logic signed [W-1:0] px;
		logic signed [W-1:0] py;
		logic clipped;
	} crossing_t;

	typedef struct {
		pair_t pair;
		logic typed;          // expectation written out below, else predicted
		crossing_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	int cycles;
	int mismatches;
	int results_seen;
	int hits_seen;
	int parallels_seen;
	int clips_seen;
	crossing_t pending_q[$];

	rsi_item_if #(.W(W)) item_bus ();
	rsi_result_if #(.W(W)) result_bus ();

	ray_segment_intersect_2d #(
		.COORD_WIDTH(W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(result_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// saturate one coordinate to the signed W-bit range
	function automatic logic signed [W-1:0] clamp_coord(exact_t v, ref logic clip);
		if (v > exact_t'(CMAX)) begin
			clip = 1'b1;
			return CMAX;
		end
		if (v < exact_t'(CMIN)) begin
			clip = 1'b1;
			return CMIN;
		end
		return v[W-1:0];
	endfunction

	// Cramer's rule on the two lines; parameter range tests done on the numerators
	function automatic crossing_t solve_pair(pair_t p);
		exact_t vx, vy, den, n1, n2;
		logic seg1, seg2, ok1, ok2, clip;
		crossing_t r;
		seg1 = (p.cmd == CMD_SEG_SEG) || (p.cmd == CMD_SEG_RAY);
		seg2 = (p.cmd == CMD_RAY_SEG) || (p.cmd == CMD_SEG_SEG);
		vx = exact_t'(p.sox) - exact_t'(p.fox);
		vy = exact_t'(p.soy) - exact_t'(p.foy);
		den = exact_t'(p.fdx) * exact_t'(p.sdy) - exact_t'(p.fdy) * exact_t'(p.sdx);
		n1 = vx * exact_t'(p.sdy) - vy * exact_t'(p.sdx);
		n2 = vx * exact_t'(p.fdy) - vy * exact_t'(p.fdx);
		r = '{hit: 1'b0, parallel: 1'b1, px: '0, py: '0, clipped: 1'b0};
		if (den == 0)
			return r;
		if (den < 0) begin
			den = -den;
			n1 = -n1;
			n2 = -n2;
		end
		ok1 = (n1 >= 0) && (!seg1 || n1 <= den);
		ok2 = (n2 >= 0) && (!seg2 || n2 <= den);
		clip = 1'b0;
		// signed division truncates toward zero, as the block does
		r.px = clamp_coord(exact_t'(p.fox) + (exact_t'(p.fdx) * n1) / den, clip);
		r.py = clamp_coord(exact_t'(p.foy) + (exact_t'(p.fdy) * n1) / den, clip);
		r.hit = ok1 && ok2;
		r.parallel = 1'b0;
		r.clipped = clip;
		return r;
	endfunction

	function automatic pair_t mk(cmd_t c, logic signed [W-1:0] a, b, d, e, f, g, h, k);
		pair_t p;
		p = '{cmd: c, fox: a, foy: b, fdx: d, fdy: e, sox: f, soy: g, sdx: h, sdy: k};
		return p;
	endfunction

	function automatic logic signed [W-1:0] small_coord(int span);
		return W'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// mostly constructed crossings with random content, some parallel, some noise
	function automatic pair_t random_pair();
		pair_t p;
		int sel, a1, a2;
		logic signed [W-1:0] cx, cy;
		sel = $urandom_range(0, 9);
		p.cmd = cmd_t'(2'($urandom));
		if (sel < 2) begin
			// full-width noise: every field gets full-width random bits
			p.fox = $urandom; p.foy = $urandom; p.fdx = $urandom; p.fdy = $urandom;
			p.sox = $urandom; p.soy = $urandom; p.sdx = $urandom; p.sdy = $urandom;
		end else if (sel < 3) begin
			// second direction a multiple of the first: parallel or collinear
			a1 = $urandom_range(1, 4);
			p.fdx = small_coord(1 << 18);
			p.fdy = small_coord(1 << 18);
			p.sdx = ($urandom_range(0, 1) ? -a1 : a1) * p.fdx;
			p.sdy = ($urandom_range(0, 1) ? -a1 : a1) * p.fdy;
			if (p.sdx * p.fdy != p.sdy * p.fdx)
				p.sdy = -p.sdy;
			p.fox = small_coord(1 << 20); p.foy = small_coord(1 << 20);
			p.sox = small_coord(1 << 20); p.soy = small_coord(1 << 20);
		end else begin
			// lines built through a common point, parameters near [0,1]
			cx = small_coord(1 << 22);
			cy = small_coord(1 << 22);
			p.fdx = small_coord(1 << 19); p.fdy = small_coord(1 << 19);
			p.sdx = small_coord(1 << 19); p.sdy = small_coord(1 << 19);
			a1 = $urandom_range(0, 8) - 2;   // quarters
			a2 = $urandom_range(0, 8) - 2;
			p.fox = cx - (p.fdx * a1) / 4 + small_coord(sel == 9 ? 1 << 10 : 0);
			p.foy = cy - (p.fdy * a1) / 4;
			p.sox = cx - (p.sdx * a2) / 4;
			p.soy = cy - (p.sdy * a2) / 4 + small_coord(sel == 8 ? 1 << 10 : 0);
		end
		return p;
	endfunction

	task automatic send_pair(pair_t p, logic typed, crossing_t want);
		item_bus.valid <= 1'b1;
		item_bus.cmd <= p.cmd;
		item_bus.first_origin_x <= p.fox;
		item_bus.first_origin_y <= p.foy;
		item_bus.first_dir_x <= p.fdx;
		item_bus.first_dir_y <= p.fdy;
		item_bus.second_origin_x <= p.sox;
		item_bus.second_origin_y <= p.soy;
		item_bus.second_dir_x <= p.sdx;
		item_bus.second_dir_y <= p.sdy;
		do
			@(posedge clk);
		while (!item_bus.ready);
		pending_q.insert(pending_q.size(), typed ? want : solve_pair(p));
	endtask

	// burst/gap pacing: after a burst, lower valid for a random gap in 2 of 3 cases
	int burst_left;
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
		if ($urandom_range(0, 2) != 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// receiver: alternates between steady ready and two stall densities
	int stall_mode;
	always @(posedge clk) begin
		if (cycles % 97 == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: begin
				result_bus.ready <= 1'b1;
			end
			1: begin
				result_bus.ready <= $urandom_range(0, 3) != 0;
			end
			default: begin
				result_bus.ready <= $urandom_range(0, 3) == 0;
			end
		endcase
	end

	// result checker: every transfer must match the oldest outstanding expectation
	always @(posedge clk) begin
		crossing_t w;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				$error("result transfer with nothing outstanding");
				mismatches++;
			end else begin
				w = pending_q.pop_front();
				hits_seen += w.hit;
				parallels_seen += w.parallel;
				clips_seen += w.clipped;
				if (result_bus.hit !== w.hit) begin
					$error("hit: expected %0b, got %0b", w.hit, result_bus.hit);
					mismatches++;
				end
				if (result_bus.parallel !== w.parallel) begin
					$error("parallel: expected %0b, got %0b", w.parallel, result_bus.parallel);
					mismatches++;
				end
				if (result_bus.point_x !== w.px) begin
					$error("point_x: expected %h, got %h", w.px, result_bus.point_x);
					mismatches++;
				end
				if (result_bus.point_y !== w.py) begin
					$error("point_y: expected %h, got %h", w.py, result_bus.point_y);
					mismatches++;
				end
				if (result_bus.clipped !== w.clipped) begin
					$error("clipped: expected %0b, got %0b", w.clipped, result_bus.clipped);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		crossing_t none_due, flat, unit_cross;
		stim_row_t rows[$];
		cycles = 0;
		mismatches = 0;
		results_seen = 0;
		hits_seen = 0;
		parallels_seen = 0;
		clips_seen = 0;
		burst_left = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		result_bus.ready = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.cmd = CMD_RAY_RAY;
		item_bus.first_origin_x = '0;
		item_bus.first_origin_y = '0;
		item_bus.first_dir_x = '0;
		item_bus.first_dir_y = '0;
		item_bus.second_origin_x = '0;
		item_bus.second_origin_y = '0;
		item_bus.second_dir_x = '0;
		item_bus.second_dir_y = '0;

		none_due = '{hit: 1'b0, parallel: 1'b0, px: '0, py: '0, clipped: 1'b0};
		flat = '{hit: 1'b0, parallel: 1'b1, px: '0, py: '0, clipped: 1'b0};
		unit_cross = '{hit: 1'b1, parallel: 1'b0, px: ONE, py: ONE, clipped: 1'b0};

		// directed table: typed where obvious, predicted otherwise
		// X through (1,1): both segments cross at their midpoints
		rows.insert(rows.size(), '{mk(CMD_SEG_SEG, 0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE,
			-2*ONE), 1'b1, unit_cross});
		rows.insert(rows.size(), '{mk(CMD_RAY_RAY, 0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE,
			-2*ONE), 1'b1, unit_cross});
		rows.insert(rows.size(), '{mk(CMD_RAY_SEG, 0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE,
			-2*ONE), 1'b1, unit_cross});
		rows.insert(rows.size(), '{mk(CMD_SEG_RAY, 0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE,
			-2*ONE), 1'b1, unit_cross});
		// parallel, collinear, zero direction, all-zero item
		rows.insert(rows.size(), '{mk(CMD_SEG_SEG, 0, 0, ONE, ONE, ONE, 0, 2*ONE, 2*ONE),
			1'b1, flat});
		rows.insert(rows.size(), '{mk(CMD_RAY_RAY, 0, 0, ONE, 0, 3*ONE, 0, -ONE, 0),
			1'b1, flat});
		rows.insert(rows.size(), '{mk(CMD_RAY_SEG, ONE, ONE, 0, 0, 0, 0, ONE, -ONE),
			1'b1, flat});
		rows.insert(rows.size(), '{mk(CMD_RAY_RAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, flat});
		rows.insert(rows.size(), '{mk(CMD_SEG_SEG, CMAX, CMIN, CMAX, CMAX, 0, 0, CMIN,
			CMIN), 1'b1, flat});
		// segment ends touching exactly (parameters 0 and 1), and just missing
		rows.insert(rows.size(), '{mk(CMD_SEG_SEG, 0, 0, ONE, 0, ONE, 0, 0, ONE),
			1'b0, none_due});
		rows.insert(rows.size(), '{mk(CMD_SEG_SEG, 0, 0, ONE, 0, ONE + 1, 0, 0, ONE),
			1'b0, none_due});
		rows.insert(rows.size(), '{mk(CMD_SEG_SEG, 0, 0, ONE, 0, 0, -ONE, 0, ONE),
			1'b0, none_due});
		// no hit behind ray origin or past seg end, hit at seg end; point still given
		rows.insert(rows.size(), '{mk(CMD_RAY_RAY, 0, 0, ONE, 0, -2*ONE, -ONE, 0, ONE),
			1'b0, none_due});
		rows.insert(rows.size(), '{mk(CMD_SEG_RAY, 0, 0, ONE, 0, 5*ONE, ONE, 0, -ONE),
			1'b0, none_due});
		rows.insert(rows.size(), '{mk(CMD_RAY_SEG, 0, 0, ONE, 0, 5*ONE, ONE, 0, -ONE),
			1'b0, none_due});
		// saturation both ways, inexact quotient, extremes of every field
		rows.insert(rows.size(), '{mk(CMD_RAY_RAY, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, 1,
			-1), 1'b0, none_due});
		rows.insert(rows.size(), '{mk(CMD_RAY_RAY, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, 1,
			-1), 1'b0, none_due});
		rows.insert(rows.size(), '{mk(CMD_SEG_SEG, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX,
			CMIN, CMIN), 1'b0, none_due});
		rows.insert(rows.size(), '{mk(CMD_RAY_SEG, 0, 0, 1, 3, 7, 0, -2, 5), 1'b0,
			none_due});
		rows.insert(rows.size(), '{mk(CMD_SEG_RAY, -1, -1, 1, 0, 0, 5, 0, -1), 1'b0,
			none_due});
		rows.insert(rows.size(), '{mk(CMD_RAY_RAY, 32'sh5555_5555, 32'shaaaa_aaaa,
			32'shaaaa_aaaa, 32'sh5555_5555, 32'sh0f0f_0f0f, 32'shf0f0_f0f0,
			32'shf0f0_f0f0, 32'sh0f0f_0f0f), 1'b0, none_due});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			pace();
			send_pair(rows[i].pair, rows[i].typed, rows[i].want);
		end
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			pace();
			send_pair(random_pair(), 1'b0, none_due);
		end
		item_bus.valid <= 1'b0;

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d results (%0d hits, %0d parallel, %0d saturated) in %0d cycles",
			results_seen, hits_seen, parallels_seen, clips_seen, cycles);
		$display("with all four pair types, endpoint touches, extremes and random stalls");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
